// ----- hdl/obpa_pkg.sv -----
// ----------------------------------------------------------------------------
// obpa_pkg
// Types and constants shared by the bin packing allocator modules.
// ----------------------------------------------------------------------------
package obpa_pkg;

  // Field widths
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned POLICY_W  = 3;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  // Bin index and count widths cover the whole range of bin counts (up to 1024)
  localparam int unsigned BIN_IDX_W = 10;
  localparam int unsigned COUNT_W   = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd1;

  // Fit policies (codes 5 to 7 behave as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST  = 3'd0;
  localparam logic [POLICY_W-1:0] POL_BEST   = 3'd1;
  localparam logic [POLICY_W-1:0] POL_WORST  = 3'd2;
  localparam logic [POLICY_W-1:0] POL_ALMOST = 3'd3;
  localparam logic [POLICY_W-1:0] POL_NEW    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  // Reset value of the capacity register
  localparam logic [WEIGHT_W-1:0] CAPACITY_RESET = 16'hFFFF;

  // Running search state handed from cell to cell
  typedef struct packed {
    logic                 active;
    logic                 has_best;
    logic [BIN_IDX_W-1:0] best_idx;
    logic [WEIGHT_W-1:0]  best_val;
    logic                 has_sec;
    logic [BIN_IDX_W-1:0] sec_idx;
    logic [WEIGHT_W-1:0]  sec_val;
  } scan_t;

  // Values held stable across the row while an item is in flight
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [POLICY_W-1:0] policy;
    logic [WEIGHT_W-1:0] capacity;
    logic [COUNT_W-1:0]  bins_open;
  } bcast_t;

  // Free space update for one bin
  typedef struct packed {
    logic                 en;
    logic                 sub;
    logic [BIN_IDX_W-1:0] idx;
    logic [WEIGHT_W-1:0]  data;
  } wr_t;

endpackage

// ----- hdl/obpa_cell.sv -----
// ----------------------------------------------------------------------------
// obpa_cell
// One bin of the row: holds its free space, folds itself into the passing
// search state and hands that state on to the next cell through its output register.
// ----------------------------------------------------------------------------
module obpa_cell import obpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BIN_IDX_W-1:0] cell_idx,
  input  bcast_t               bcast,
  input  wr_t                  wr,
  input  scan_t                scan_in,
  output scan_t                scan_out
);

  logic [WEIGHT_W-1:0] free_space;
  logic                is_open;
  logic                fits;
  logic [WEIGHT_W-1:0] leftover;
  logic [WEIGHT_W-1:0] best_lim;
  scan_t               scan_next;

  // Judge this bin against the item
  assign is_open  = {1'b0, cell_idx} < bcast.bins_open;
  assign fits     = scan_in.active && is_open && (free_space >= bcast.weight);
  assign leftover = free_space - bcast.weight;
  assign best_lim = scan_in.has_best ? scan_in.best_val : bcast.capacity;

  // Update the running choice
  always_comb begin
    scan_next = scan_in;
    if (fits) begin
      unique case (bcast.policy)
        POL_BEST: begin
          if (leftover < best_lim) begin
            scan_next.has_best = 1'b1;
            scan_next.best_idx = cell_idx;
            scan_next.best_val = leftover;
          end
        end
        POL_WORST: begin
          if (!scan_in.has_best || leftover > scan_in.best_val) begin
            scan_next.has_best = 1'b1;
            scan_next.best_idx = cell_idx;
            scan_next.best_val = leftover;
          end
        end
        POL_ALMOST: begin
          if (!scan_in.has_sec || leftover > scan_in.sec_val) begin
            if (!scan_in.has_best || leftover > scan_in.best_val) begin
              scan_next.has_sec  = scan_in.has_best;
              scan_next.sec_idx  = scan_in.best_idx;
              scan_next.sec_val  = scan_in.best_val;
              scan_next.has_best = 1'b1;
              scan_next.best_idx = cell_idx;
              scan_next.best_val = leftover;
            end else begin
              scan_next.has_sec = 1'b1;
              scan_next.sec_idx = cell_idx;
              scan_next.sec_val = leftover;
            end
          end
        end
        default: begin
          // First fit: keep the earliest bin that fits
          if (!scan_in.has_best) begin
            scan_next.has_best = 1'b1;
            scan_next.best_idx = cell_idx;
            scan_next.best_val = leftover;
          end
        end
      endcase
    end
  end

  // Hand the search state on
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.active <= 1'b0;
    end else begin
      scan_out.active <= scan_next.active;
    end
    scan_out.has_best <= scan_next.has_best;
    scan_out.best_idx <= scan_next.best_idx;
    scan_out.best_val <= scan_next.best_val;
    scan_out.has_sec  <= scan_next.has_sec;
    scan_out.sec_idx  <= scan_next.sec_idx;
    scan_out.sec_val  <= scan_next.sec_val;
  end

  // Update the free space of this bin
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      free_space <= wr.sub ? (free_space - bcast.weight) : wr.data;
    end
  end

endmodule

// ----- hdl/obpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// obpa_ctrl
// Sequencer of the allocator: configuration registers, open bin count,
// launch of the search into the row, final choice and result register.
// ----------------------------------------------------------------------------
module obpa_ctrl import obpa_pkg::*; #(
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ID_W-1:0]       item_id,
  input  logic [WEIGHT_W-1:0]   item_weight,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       placed_id,
  output logic [OUT_IDX_W-1:0]  bin_index,
  output logic                  opened_new,
  output logic [STATUS_W-1:0]   status,
  output bcast_t                bcast,
  output wr_t                   wr,
  output scan_t                 scan_head,
  input  scan_t                 scan_tail
);

  localparam int unsigned USED_W = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam logic [WEIGHT_W-1:0] W_MASK = WEIGHT_W'((33'd1 << USED_W) - 33'd1);
  localparam logic [COUNT_W-1:0]  FULL   = COUNT_W'(MAX_BINS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]           state;
  logic [WEIGHT_W-1:0]  capacity;
  logic [POLICY_W-1:0]  policy;
  logic [COUNT_W-1:0]   bins_open;
  logic [ID_W-1:0]      id_r;
  logic [WEIGHT_W-1:0]  weight_r;
  scan_t                res;

  logic                 in_xfer;
  logic                 fire;
  logic                 use_sec;
  logic                 has_pick;
  logic [BIN_IDX_W-1:0] pick_idx;
  logic                 full;
  logic                 oversize;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign fire     = (state == S_DECIDE) && (!out_valid || out_ready);

  assign bcast.weight    = weight_r;
  assign bcast.policy    = policy;
  assign bcast.capacity  = capacity;
  assign bcast.bins_open = bins_open;

  // Pick the bin from the finished search
  assign use_sec  = (policy == POL_ALMOST) && res.has_sec;
  assign has_pick = use_sec || res.has_best;
  assign pick_idx = use_sec ? res.sec_idx : res.best_idx;
  assign full     = (bins_open == FULL);
  assign oversize = weight_r > capacity;

  // Drive the bin update on the deciding cycle
  always_comb begin
    wr.en   = 1'b0;
    wr.sub  = 1'b0;
    wr.idx  = pick_idx;
    wr.data = '0;
    if (fire) begin
      if (has_pick) begin
        wr.en  = 1'b1;
        wr.sub = 1'b1;
      end else if (!full) begin
        wr.en   = 1'b1;
        wr.idx  = bins_open[BIN_IDX_W-1:0];
        wr.data = oversize ? '0 : (capacity - weight_r);
      end
    end
  end

  // Launch the search into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_head.active <= 1'b0;
    end else begin
      scan_head.active <= in_xfer && (policy != POL_NEW);
    end
    scan_head.has_best <= 1'b0;
    scan_head.best_idx <= '0;
    scan_head.best_val <= '0;
    scan_head.has_sec  <= 1'b0;
    scan_head.sec_idx  <= '0;
    scan_head.sec_val  <= '0;
  end

  // Sequence one item at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (policy == POL_NEW) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_tail.active) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the item and the search outcome
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      id_r     <= item_id;
      weight_r <= item_weight & W_MASK;
      res      <= '0;
    end else if ((state == S_SCAN) && scan_tail.active) begin
      res <= scan_tail;
    end
  end

  // Configuration registers and open bin count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RESET;
      policy    <= POL_FIRST;
      bins_open <= '0;
    end else begin
      if (fire && !has_pick && !full) begin
        bins_open <= bins_open + COUNT_W'(1);
      end
      if (cfg_wr_en && (cfg_index == REG_CAPACITY)) begin
        capacity  <= cfg_data;
        bins_open <= '0;
      end
      if (cfg_wr_en && (cfg_index == REG_POLICY)) begin
        policy <= cfg_data[POLICY_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      placed_id <= id_r;
      if (has_pick) begin
        bin_index  <= pick_idx[OUT_IDX_W-1:0];
        opened_new <= 1'b0;
        status     <= ST_PLACED;
      end else if (full) begin
        bin_index  <= '0;
        opened_new <= 1'b0;
        status     <= ST_REJECTED;
      end else begin
        bin_index  <= bins_open[OUT_IDX_W-1:0];
        opened_new <= 1'b1;
        status     <= oversize ? ST_OVERSIZE : ST_PLACED;
      end
    end
  end

endmodule

// ----- hdl/online_bin_packing_allocator_top.sv -----
// ----------------------------------------------------------------------------
// online_bin_packing_allocator_top
// Online bin packing allocator with first, best, worst, almost-worst fit and
// always-new policies over a row of bin cells.
// ----------------------------------------------------------------------------
// Each transfer on the input gives one result and is placed in one bin, unless
// every bin is open and none fits, when it is rejected. The free space of every
// bin sits in its own cell; a search token walks the row one cell per cycle, so
// the time from an item's transfer to the next input transfer is set by the
// length of the cell row; the always-new policy skips the walk. The result
// waits in an output register, while the next item is already taken. Writing
// the capacity register empties all bins; write configuration only while idle.
// ----------------------------------------------------------------------------
module online_bin_packing_allocator_top import obpa_pkg::*; #(
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ID_W-1:0]       item_id,
  input  logic [WEIGHT_W-1:0]   item_weight,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       placed_id,
  output logic [OUT_IDX_W-1:0]  bin_index,
  output logic                  opened_new,
  output logic [STATUS_W-1:0]   status
);

  bcast_t bcast;
  wr_t    wr;
  scan_t  chain [MAX_BINS+1];

  obpa_ctrl #(
    .MAX_BINS    (MAX_BINS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item_id     (item_id),
    .item_weight (item_weight),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .placed_id   (placed_id),
    .bin_index   (bin_index),
    .opened_new  (opened_new),
    .status      (status),
    .bcast       (bcast),
    .wr          (wr),
    .scan_head   (chain[0]),
    .scan_tail   (chain[MAX_BINS])
  );

  // Row of bin cells, one per bin
  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    obpa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (BIN_IDX_W'(i)),
      .bcast    (bcast),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

endmodule

// ----- hdl/obpa_checker.sv -----
// ----------------------------------------------------------------------------
// obpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module obpa_checker import obpa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ID_W-1:0]       placed_id,
  input logic [OUT_IDX_W-1:0]  bin_index,
  input logic                  opened_new,
  input logic [STATUS_W-1:0]   status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(placed_id) && $stable(bin_index))
    else $error("stalled result changed");

  // Take one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a transfer");

  // A rejected item opens nothing and names bin zero
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_REJECTED) |-> !opened_new && (bin_index == '0))
    else $error("rejected item carries a bin");

  // An oversize item always gets a new bin
  a_oversize: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OVERSIZE) |-> opened_new)
    else $error("oversize item placed in an existing bin");

endmodule

bind online_bin_packing_allocator_top obpa_checker u_obpa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .placed_id  (placed_id),
  .bin_index  (bin_index),
  .opened_new (opened_new),
  .status     (status)
);
